// File: hw/rtl/ts_cc_pkg.sv
// ----------------------------------------------------------------------------
// ts_cc_pkg
// Shared types and constants of the transport stream continuity checker:
// header field layout, result codes and the lookup result handed between
// the table sequencer and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package ts_cc_pkg;

    localparam int unsigned HDR_W   = 32;
    localparam int unsigned PID_W   = 13;
    localparam int unsigned CC_W    = 4;
    localparam int unsigned STAT_W  = 3;
    localparam int unsigned TOT_W   = 32;
    localparam int unsigned OUT_W   = STAT_W + CC_W + TOT_W + TOT_W + 1;

    localparam logic [7:0]       SYNC_BYTE = 8'h47;
    localparam logic [PID_W-1:0] NULL_PID  = 13'h1FFF;
    localparam logic [PID_W-1:0] ZERO_PID  = 13'h0000;

    typedef enum logic [STAT_W-1:0] {
        ST_SKIPPED   = 3'd0,
        ST_NEW       = 3'd1,
        ST_IN_ORDER  = 3'd2,
        ST_CC_ERROR  = 3'd3,
        ST_UNCHECKED = 3'd4,
        ST_BAD_SYNC  = 3'd5,
        ST_FULL      = 3'd6
    } t_status;

    typedef struct packed {
        logic            found;
        logic            full;
        logic [CC_W-1:0] stored_cc;
    } t_lookup;

    function automatic logic [7:0] hdr_sync(input logic [HDR_W-1:0] hdr);
        return hdr[31:24];
    endfunction

    function automatic logic [PID_W-1:0] hdr_pid(input logic [HDR_W-1:0] hdr);
        return hdr[20:8];
    endfunction

    function automatic logic hdr_payload(input logic [HDR_W-1:0] hdr);
        return hdr[4];
    endfunction

    function automatic logic [CC_W-1:0] hdr_cc(input logic [HDR_W-1:0] hdr);
        return hdr[3:0];
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/ts_cc_table.sv
// ----------------------------------------------------------------------------
// ts_cc_table
// PID and continuity counter table: one write port with separate enables for
// the PID and counter halves, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module ts_cc_table
    import ts_cc_pkg::*;
#(
    parameter int unsigned DEPTH = 16,
    parameter int unsigned IDX_W = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_pid_we,
    input  wire logic             i_cc_we,
    input  wire logic [IDX_W-1:0] i_waddr,
    input  wire logic [PID_W-1:0] i_wpid,
    input  wire logic [CC_W-1:0]  i_wcc,
    input  wire logic             i_re,
    input  wire logic [IDX_W-1:0] i_raddr,
    output logic      [PID_W-1:0] o_rpid,
    output logic      [CC_W-1:0]  o_rcc
);

    logic [PID_W-1:0] pid_mem [DEPTH];
    logic [CC_W-1:0]  cc_mem  [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_pid_we) begin
            pid_mem[i_waddr] <= i_wpid;
        end
        if (i_cc_we) begin
            cc_mem[i_waddr] <= i_wcc;
        end
        if (i_re) begin
            o_rpid <= pid_mem[i_raddr];
            o_rcc  <= cc_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/ts_cc_search.sv
// ----------------------------------------------------------------------------
// ts_cc_search
// Table sequencer: scans the filled part of the PID table one entry per
// cycle through the shared compare, then appends a new PID while the table
// has room or rewrites the stored counter of the matching entry.
// ----------------------------------------------------------------------------
`default_nettype none

module ts_cc_search
    import ts_cc_pkg::*;
#(
    parameter int unsigned DEPTH = 16,
    parameter int unsigned IDX_W = 4,
    parameter int unsigned CNT_W = 5
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [PID_W-1:0] i_pid,
    input  wire logic [CC_W-1:0]  i_cc,
    output logic                  o_done,
    output t_lookup               o_res
);

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } t_state;

    t_state           r_state;
    logic [PID_W-1:0] r_pid;
    logic [CC_W-1:0]  r_cc;
    logic [CNT_W-1:0] r_fill;
    logic [CNT_W-1:0] r_rd_idx;
    logic             r_cmp_valid;
    logic [IDX_W-1:0] r_cmp_idx;

    logic [PID_W-1:0] rpid;
    logic [CC_W-1:0]  rcc;
    logic             more;
    logic             match;
    logic             miss_end;
    logic             full;
    logic             pid_we;
    logic             cc_we;
    logic             re;
    logic [IDX_W-1:0] waddr;

    assign more     = (r_rd_idx < r_fill);
    assign match    = (r_state == S_SCAN) && r_cmp_valid && (rpid == r_pid);
    assign miss_end = (r_state == S_SCAN) && !r_cmp_valid && !more;
    assign full     = (r_fill == CNT_W'(DEPTH));
    assign re       = (r_state == S_SCAN) && more && !match;
    assign cc_we    = match || (miss_end && !full);
    assign pid_we   = miss_end && !full;
    assign waddr    = match ? r_cmp_idx : r_fill[IDX_W-1:0];

    ts_cc_table #(
        .DEPTH (DEPTH),
        .IDX_W (IDX_W)
    ) u_table (
        .i_clk    (i_clk),
        .i_pid_we (pid_we),
        .i_cc_we  (cc_we),
        .i_waddr  (waddr),
        .i_wpid   (r_pid),
        .i_wcc    (r_cc),
        .i_re     (re),
        .i_raddr  (r_rd_idx[IDX_W-1:0]),
        .o_rpid   (rpid),
        .o_rcc    (rcc)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_rd_idx    <= '0;
            r_cmp_valid <= 1'b0;
            o_done      <= 1'b0;
        end else begin
            o_done <= match || miss_end;
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_pid       <= i_pid;
                        r_cc        <= i_cc;
                        r_rd_idx    <= '0;
                        r_cmp_valid <= 1'b0;
                        r_state     <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    r_cmp_valid <= re;
                    r_cmp_idx   <= r_rd_idx[IDX_W-1:0];
                    if (re) begin
                        r_rd_idx <= r_rd_idx + CNT_W'(1);
                    end
                    if (match || miss_end) begin
                        o_res.found     <= match;
                        o_res.full      <= miss_end && full;
                        o_res.stored_cc <= rcc;
                        r_state         <= S_IDLE;
                    end
                    if (pid_we) begin
                        r_fill <= r_fill + CNT_W'(1);
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/ts_continuity_checker_top.sv
// ----------------------------------------------------------------------------
// ts_continuity_checker_top
// Transport stream continuity counter checker, one packet header per transfer.
// ----------------------------------------------------------------------------
// Each input transfer carries the four header bytes of one packet and yields
// exactly one result transfer. Headers that are skipped (checking off, table
// overflowed, PID zero) or have a bad sync byte bypass the table lookup.
// Headers with a PID are looked up in the entries in use of a table of
// TABLE_ENTRIES entries that is read one entry per cycle through a single
// read port; the input is not ready while a header is in work. A finished
// result waits in the output register, and the next header is taken
// meanwhile. PIDs enter the table in arrival order and are never removed;
// once it is full the overflow flag sticks until reset and every later
// header is skipped. The check_enable register is to be written through the
// configuration channel only while the block is idle; the block itself does
// not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module ts_continuity_checker_top
    import ts_cc_pkg::*;
#(
    parameter int unsigned TABLE_ENTRIES = 16
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_valid,
    output logic                  o_cfg_ready,
    input  wire logic             i_cfg_data,   // check_enable
    input  wire logic             i_s_tvalid,
    output logic                  o_s_tready,
    input  wire logic [HDR_W-1:0] i_s_tdata,    // header_word
    output logic                  o_m_tvalid,
    input  wire logic             i_m_tready,
    // status[2:0], expected_count[6:3], cc_error_total[38:7],
    // invalid_total[70:39], overflowed[71]
    output logic      [OUT_W-1:0] o_m_tdata
);

    localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);

    typedef enum logic [1:0] {
        T_IDLE,
        T_SEARCH,
        T_PUSH
    } t_state;

    t_state           r_state;
    logic             r_en;
    logic             r_ovf;
    logic [TOT_W-1:0] r_err;
    logic [TOT_W-1:0] r_inv;
    logic [HDR_W-1:0] r_hdr;
    t_status          r_p_status;
    logic [CC_W-1:0]  r_p_exp;

    logic             accept;
    logic             start;
    logic             done;
    t_lookup          res;
    logic [CC_W-1:0]  n_exp;
    t_status          n_status;

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = (r_state == T_IDLE);
    assign accept      = i_s_tvalid && o_s_tready;
    assign start       = accept && r_en && !r_ovf
                         && (hdr_sync(i_s_tdata) == SYNC_BYTE)
                         && (hdr_pid(i_s_tdata) != ZERO_PID);

    ts_cc_search #(
        .DEPTH (TABLE_ENTRIES),
        .IDX_W (IDX_W),
        .CNT_W (CNT_W)
    ) u_search (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_pid   (hdr_pid(i_s_tdata)),
        .i_cc    (hdr_cc(i_s_tdata)),
        .o_done  (done),
        .o_res   (res)
    );

    assign n_exp = res.stored_cc + CC_W'(1);

    always_comb begin
        priority if (res.found) begin
            if ((hdr_pid(r_hdr) != NULL_PID) && hdr_payload(r_hdr)) begin
                n_status = (n_exp != hdr_cc(r_hdr)) ? ST_CC_ERROR : ST_IN_ORDER;
            end else begin
                n_status = ST_UNCHECKED;
            end
        end else if (res.full) begin
            n_status = ST_FULL;
        end else begin
            n_status = ST_NEW;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= T_IDLE;
            r_en       <= 1'b0;
            r_ovf      <= 1'b0;
            r_err      <= '0;
            r_inv      <= '0;
            o_m_tvalid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_en <= i_cfg_data;
            end
            if (o_m_tvalid && i_m_tready && (r_state != T_PUSH)) begin
                o_m_tvalid <= 1'b0;
            end
            unique case (r_state)
                T_IDLE: begin
                    if (accept) begin
                        r_hdr   <= i_s_tdata;
                        r_p_exp <= '0;
                        priority if (!r_en || r_ovf) begin
                            r_p_status <= ST_SKIPPED;
                            r_state    <= T_PUSH;
                        end else if (hdr_sync(i_s_tdata) != SYNC_BYTE) begin
                            r_inv      <= r_inv + TOT_W'(1);
                            r_p_status <= ST_BAD_SYNC;
                            r_state    <= T_PUSH;
                        end else if (hdr_pid(i_s_tdata) == ZERO_PID) begin
                            r_p_status <= ST_SKIPPED;
                            r_state    <= T_PUSH;
                        end else begin
                            r_state <= T_SEARCH;
                        end
                    end
                end
                T_SEARCH: begin
                    if (done) begin
                        r_p_status <= n_status;
                        r_p_exp    <= res.found ? n_exp : '0;
                        if (n_status == ST_CC_ERROR) begin
                            r_err <= r_err + TOT_W'(1);
                        end
                        if (n_status == ST_FULL) begin
                            r_ovf <= 1'b1;
                        end
                        r_state <= T_PUSH;
                    end
                end
                T_PUSH: begin
                    if (!o_m_tvalid || i_m_tready) begin
                        o_m_tvalid <= 1'b1;
                        o_m_tdata  <= {r_ovf, r_inv, r_err, r_p_exp, r_p_status};
                        r_state    <= T_IDLE;
                    end
                end
                default: begin
                    r_state <= T_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/ts_cc_checker.sv
// ----------------------------------------------------------------------------
// ts_cc_checker
// Port-level checks of the continuity checker, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ts_cc_checker
    import ts_cc_pkg::*;
(
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             i_s_tvalid,
    input wire logic             o_s_tready,
    input wire logic             o_m_tvalid,
    input wire logic             i_m_tready,
    input wire logic [OUT_W-1:0] o_m_tdata
);

    logic [STAT_W-1:0] st;
    logic [CC_W-1:0]   ex;

    assign st = o_m_tdata[STAT_W-1:0];
    assign ex = o_m_tdata[STAT_W+CC_W-1:STAT_W];

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result changed while stalled");

    a_busy_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("input ready right after a header transfer");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> st != 3'd7)
        else $error("undefined status code");

    a_expect_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (st == ST_SKIPPED || st == ST_NEW || st == ST_BAD_SYNC
                       || st == ST_FULL) |-> ex == '0)
        else $error("expected count set for a pid not found");

    a_full_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (st == ST_FULL) |-> o_m_tdata[OUT_W-1])
        else $error("table full without overflow flag");

endmodule

bind ts_continuity_checker_top ts_cc_checker u_ts_cc_checker (.*);

`default_nettype wire

// File: test/ts_continuity_checker_top_tb.sv
// ----------------------------------------------------------------------------
// ts_continuity_checker_top_tb
// Self-checking bench for the transport stream continuity checker.
// ----------------------------------------------------------------------------
// Packet headers are queued by the stimulus process and sent by a clocked
// driver with random idle bursts, while the result side stalls at random.
// Every accepted header runs through a local model of the PID table and the
// error counters; the predicted result is queued and compared field by field
// with the next result transfer. The run covers directed corner headers,
// long well-formed streams on a small PID pool with injected counter jumps,
// bad sync bytes and PID zero, a phase with checking off, and finally a table
// fill that trips the sticky overflow flag.
// ----------------------------------------------------------------------------

module ts_continuity_checker_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import ts_cc_pkg::*;

    localparam int unsigned TABLE_ENTRIES = 16;
    localparam int unsigned QUIET_LIMIT   = 2000;
    localparam int unsigned PRINT_LIMIT   = 50;

    typedef struct {
        t_status          status;
        logic [CC_W-1:0]  next_cc;
        logic [TOT_W-1:0] cc_errors;
        logic [TOT_W-1:0] sync_errors;
        logic             overflow;
    } t_hdr_verdict;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             i_cfg_valid;
    logic             o_cfg_ready;
    logic             i_cfg_data;
    logic             i_s_tvalid;
    logic             o_s_tready;
    logic [HDR_W-1:0] i_s_tdata;
    logic             o_m_tvalid;
    logic             i_m_tready;
    logic [OUT_W-1:0] o_m_tdata;

    // header model state
    logic             check_on;
    logic [PID_W-1:0] pid_table [TABLE_ENTRIES];
    logic [CC_W-1:0]  cc_table [TABLE_ENTRIES];
    logic [TOT_W-1:0] cc_error_count;
    logic [TOT_W-1:0] sync_error_count;
    logic             table_overflow;

    logic [HDR_W-1:0] header_queue [$];
    t_hdr_verdict     pending_results [$];

    // stimulus bookkeeping
    logic [PID_W-1:0] stream_pids [$];
    logic [CC_W-1:0]  stream_cc [logic [PID_W-1:0]];
    bit               pid_used [logic [PID_W-1:0]];

    bit               idle_in;
    bit               idle_out;
    bit               hdr_taken;
    int               send_gap;
    int               stall_left;
    int               quiet_cycles;
    int               mismatches;

    ts_continuity_checker_top #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)
    );

    always #5 i_clk = ~i_clk;

    function automatic t_hdr_verdict check_header(input logic [HDR_W-1:0] hdr);
        t_hdr_verdict     v;
        logic [PID_W-1:0] pid;
        logic [CC_W-1:0]  next_cc;
        int               slot;
        bit               found;
        int               i;
        v.status  = ST_SKIPPED;
        v.next_cc = '0;
        pid       = hdr[20:8];
        slot      = -1;
        found     = 1'b0;
        if (check_on && !table_overflow) begin
            if (hdr[31:24] != SYNC_BYTE) begin
                sync_error_count = sync_error_count + 1;
                v.status = ST_BAD_SYNC;
            end else if (pid != ZERO_PID) begin
                for (i = 0; i < TABLE_ENTRIES; i++) begin
                    if (slot < 0) begin
                        if (pid_table[i] == pid) begin
                            slot  = i;
                            found = 1'b1;
                        end else if (pid_table[i] == ZERO_PID) begin
                            slot = i;
                        end
                    end
                end
                if (slot < 0) begin
                    table_overflow = 1'b1;
                    v.status = ST_FULL;
                end else if (!found) begin
                    pid_table[slot] = pid;
                    cc_table[slot]  = hdr[3:0];
                    v.status = ST_NEW;
                end else begin
                    next_cc   = cc_table[slot] + 1'b1;
                    v.next_cc = next_cc;
                    if (pid != NULL_PID && hdr[4]) begin
                        if (next_cc != hdr[3:0]) begin
                            cc_error_count = cc_error_count + 1;
                            v.status = ST_CC_ERROR;
                        end else begin
                            v.status = ST_IN_ORDER;
                        end
                    end else begin
                        v.status = ST_UNCHECKED;
                    end
                    cc_table[slot] = hdr[3:0];
                end
            end
        end
        v.cc_errors   = cc_error_count;
        v.sync_errors = sync_error_count;
        v.overflow    = table_overflow;
        return v;
    endfunction

    task automatic report_mismatch(input string what, input logic [TOT_W-1:0] got,
                                   input logic [TOT_W-1:0] want);
        mismatches++;
        if (mismatches <= PRINT_LIMIT)
            $display("%0t: %s: got %0h, want %0h", $time, what, got, want);
    endtask

    function automatic logic [HDR_W-1:0] make_header(input logic [7:0] sync,
                                                     input logic [PID_W-1:0] pid,
                                                     input logic [1:0] afc,
                                                     input logic [CC_W-1:0] cc);
        logic [2:0] flags;
        logic [1:0] scramble;
        flags    = 3'($urandom_range(0, 7));
        scramble = 2'($urandom_range(0, 3));
        return {sync, flags, pid, scramble, afc, cc};
    endfunction

    task automatic queue_stream_headers(input int count);
        int               n;
        int               pick;
        logic [7:0]       sync;
        logic [PID_W-1:0] pid;
        logic [1:0]       afc;
        logic [CC_W-1:0]  cc;
        for (n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            pid  = stream_pids[$urandom_range(0, stream_pids.size() - 1)];
            afc  = 2'($urandom_range(0, 3));
            if ($urandom_range(0, 4) != 0)
                afc[0] = 1'b1;
            if ($urandom_range(0, 6) == 0)
                cc = 4'($urandom_range(0, 15));
            else
                cc = stream_cc[pid] + 1'b1;
            sync = SYNC_BYTE;
            if (pick < 6) begin
                sync = 8'($urandom_range(0, 255));
                if (sync == SYNC_BYTE)
                    sync = sync ^ 8'h80;
            end else if (pick < 12) begin
                pid = ZERO_PID;
            end else begin
                stream_cc[pid] = cc;
            end
            header_queue.push_back(make_header(sync, pid, afc, cc));
        end
    endtask

    task automatic add_stream_pid(input logic [PID_W-1:0] pid);
        stream_pids.push_back(pid);
        stream_cc[pid] = 4'($urandom_range(0, 15));
        pid_used[pid]  = 1'b1;
    endtask

    task automatic wait_drained();
        while (header_queue.size() != 0 || i_s_tvalid || pending_results.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_check_enable(input logic value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        check_on = value;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // header driver
    always @(negedge i_clk) begin : drive_headers
        logic             next_valid;
        logic [HDR_W-1:0] next_data;
        next_valid = i_s_tvalid;
        next_data  = i_s_tdata;
        if (!i_s_tvalid || hdr_taken) begin
            next_valid = 1'b0;
            if (send_gap > 0) begin
                send_gap--;
            end else if (header_queue.size() > 0) begin
                if (idle_in && $urandom_range(0, 5) == 0) begin
                    send_gap = $urandom_range(1, 17) - 1;
                end else begin
                    next_valid = 1'b1;
                    next_data  = header_queue.pop_front();
                end
            end
        end
        hdr_taken = 1'b0;
        i_s_tvalid <= next_valid;
        i_s_tdata  <= next_data;
    end

    // result-side backpressure
    always @(negedge i_clk) begin : drive_ready
        logic next_ready;
        next_ready = 1'b1;
        if (stall_left > 0) begin
            stall_left--;
            next_ready = 1'b0;
        end else if (idle_out && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 17) - 1;
            next_ready = 1'b0;
        end
        i_m_tready <= next_ready;
    end

    // predict, check and watch for a hang
    always @(posedge i_clk) begin : monitor
        t_hdr_verdict want;
        bit           moved;
        moved = 1'b0;
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready) begin
                pending_results.push_back(check_header(i_s_tdata));
                hdr_taken = 1'b1;
                moved     = 1'b1;
            end
            if (o_m_tvalid && i_m_tready) begin
                moved = 1'b1;
                if (pending_results.size() == 0) begin
                    report_mismatch("result with no header", o_m_tdata[TOT_W-1:0], '0);
                end else begin
                    want = pending_results.pop_front();
                    if (o_m_tdata[2:0] != want.status)
                        report_mismatch("status", o_m_tdata[2:0], want.status);
                    if (o_m_tdata[6:3] != want.next_cc)
                        report_mismatch("expected_count", o_m_tdata[6:3], want.next_cc);
                    if (o_m_tdata[38:7] != want.cc_errors)
                        report_mismatch("cc_error_total", o_m_tdata[38:7], want.cc_errors);
                    if (o_m_tdata[70:39] != want.sync_errors)
                        report_mismatch("invalid_total", o_m_tdata[70:39], want.sync_errors);
                    if (o_m_tdata[71] != want.overflow)
                        report_mismatch("overflowed", o_m_tdata[71], want.overflow);
                end
            end
            if (i_cfg_valid && o_cfg_ready)
                moved = 1'b1;
        end
        if (moved || !i_rst_n)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin : stimulus
        localparam logic [PID_W-1:0] PID_LOW  = 13'h0001;
        localparam logic [PID_W-1:0] PID_HIGH = 13'h1FFE;
        logic [PID_W-1:0] pid;
        int               n;

        i_rst_n          = 1'b0;
        i_cfg_valid      = 1'b0;
        i_cfg_data       = 1'b0;
        i_s_tvalid       = 1'b0;
        i_s_tdata        = '0;
        i_m_tready       = 1'b0;
        check_on         = 1'b0;
        cc_error_count   = '0;
        sync_error_count = '0;
        table_overflow   = 1'b0;
        for (n = 0; n < TABLE_ENTRIES; n++) begin
            pid_table[n] = ZERO_PID;
            cc_table[n]  = '0;
        end
        idle_in      = 1'b0;
        idle_out     = 1'b0;
        hdr_taken    = 1'b0;
        send_gap     = 0;
        stall_left   = 0;
        quiet_cycles = 0;
        mismatches   = 0;

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // checking off: everything is skipped
        write_check_enable(1'b0);
        header_queue.push_back(make_header(SYNC_BYTE, PID_LOW, 2'b01, 4'd3));
        header_queue.push_back(make_header(8'h00, PID_HIGH, 2'b11, 4'd0));
        header_queue.push_back(make_header(SYNC_BYTE, NULL_PID, 2'b01, 4'd15));
        wait_drained();

        write_check_enable(1'b1);
        header_queue.push_back(make_header(8'h00, PID_LOW, 2'b01, 4'd0));
        header_queue.push_back(make_header(8'hFF, PID_LOW, 2'b01, 4'd0));
        header_queue.push_back(make_header(SYNC_BYTE, ZERO_PID, 2'b01, 4'd4));
        header_queue.push_back(make_header(SYNC_BYTE, PID_LOW, 2'b01, 4'd15));
        header_queue.push_back(make_header(SYNC_BYTE, PID_LOW, 2'b01, 4'd0));
        header_queue.push_back(make_header(SYNC_BYTE, PID_LOW, 2'b01, 4'd5));
        header_queue.push_back(make_header(SYNC_BYTE, PID_LOW, 2'b10, 4'd6));
        header_queue.push_back(make_header(SYNC_BYTE, PID_LOW, 2'b00, 4'd9));
        header_queue.push_back(make_header(SYNC_BYTE, PID_LOW, 2'b11, 4'd10));
        header_queue.push_back(make_header(SYNC_BYTE, NULL_PID, 2'b01, 4'd0));
        header_queue.push_back(make_header(SYNC_BYTE, NULL_PID, 2'b01, 4'd7));
        header_queue.push_back(make_header(SYNC_BYTE, PID_HIGH, 2'b11, 4'd0));
        header_queue.push_back(make_header(SYNC_BYTE, PID_HIGH, 2'b11, 4'd1));
        header_queue.push_back(make_header(SYNC_BYTE, PID_HIGH, 2'b11, 4'd1));
        header_queue.push_back(32'hFFFF_FFFF);
        header_queue.push_back({SYNC_BYTE, 24'h1F_FFFF});
        header_queue.push_back({SYNC_BYTE, 24'h00_0000});
        wait_drained();

        add_stream_pid(PID_LOW);
        add_stream_pid(PID_HIGH);
        add_stream_pid(NULL_PID);
        while (stream_pids.size() < 11) begin
            pid = PID_W'($urandom_range(1, 13'h1FFE));
            if (!pid_used.exists(pid))
                add_stream_pid(pid);
        end

        // first batch quiet on both sides, second batch with bursts
        queue_stream_headers(100);
        wait_drained();
        idle_in  = 1'b1;
        idle_out = 1'b1;
        queue_stream_headers(200);
        wait_drained();

        write_check_enable(1'b0);
        queue_stream_headers(40);
        wait_drained();
        write_check_enable(1'b1);

        queue_stream_headers(300);
        wait_drained();

        // no idling from here on; fill the table until it overflows
        idle_in  = 1'b0;
        idle_out = 1'b0;
        queue_stream_headers(60);
        n = 0;
        while (n < 8) begin
            pid = PID_W'($urandom_range(1, 13'h1FFE));
            if (!pid_used.exists(pid)) begin
                pid_used[pid] = 1'b1;
                header_queue.push_back(make_header(SYNC_BYTE, pid, 2'b01,
                                                   4'($urandom_range(0, 15))));
                n++;
            end
        end
        queue_stream_headers(10);
        wait_drained();

        repeat (30) @(posedge i_clk);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
